// ----- hdl/rldc_pkg.sv -----
`default_nettype none

package rldc_pkg;

  // digit count of the run length counter, as set at the top level
  localparam int COUNT_DIGITS_DEF = 5;
  // the counter never uses more digits than this
  localparam int MAX_DIGITS = 9;
  // run requests waiting between front and back
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] ASCII_ZERO = 8'h30;

endpackage

`default_nettype wire

// ----- hdl/rldc_if.sv -----
`default_nettype none

// input channel: one string byte per request
interface rldc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_string;

  modport source (output valid, output symbol, output end_of_string, input ready);
  modport sink (input valid, input symbol, input end_of_string, output ready);
endinterface

// result channel: one output byte per request
interface rldc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

// ----- hdl/rldc_front.sv -----
`default_nettype none

module rldc_front import rldc_pkg::*; #(
  parameter int DIGITS = COUNT_DIGITS_DEF,
  localparam int BCD_W = 4 * DIGITS,
  localparam int JOB_W = 1 + 8 + BCD_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  rldc_in_if.sink               in_req,
  output logic                  push,
  output logic [JOB_W-1:0]      push_data,
  input  wire logic             q_full
);

  localparam logic [BCD_W-1:0] BCD_MAX = {DIGITS{4'h9}};
  localparam logic [BCD_W-1:0] BCD_ONE = BCD_W'(1);

  logic             run_open_r, run_open_nxt;
  logic [7:0]       run_byte_r, run_byte_nxt;
  logic [BCD_W-1:0] run_len_r, run_len_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [JOB_W-1:0] pend_job_r, pend_job_nxt;

  logic             accept;
  logic             same;
  logic             close_new;
  logic [BCD_W-1:0] len_inc;
  logic [JOB_W-1:0] new_job;

  assign in_req.ready = !pend_v_r && !q_full;
  assign accept       = in_req.valid && in_req.ready;
  assign same         = run_open_r && (in_req.symbol == run_byte_r);

  // decimal increment, carry rippling through nines
  always_comb begin
    logic carry;
    logic [3:0] d;
    carry   = 1'b1;
    len_inc = run_len_r;
    for (int i = 0; i < DIGITS; i++) begin
      d = run_len_r[i*4 +: 4];
      if (carry) begin
        if (d == 4'h9) begin
          len_inc[i*4 +: 4] = 4'h0;
        end else begin
          len_inc[i*4 +: 4] = d + 4'h1;
          carry             = 1'b0;
        end
      end
    end
  end

  assign close_new = in_req.end_of_string || (BCD_ONE == BCD_MAX);
  assign new_job   = {in_req.end_of_string, in_req.symbol, BCD_ONE};

  always_comb begin
    run_open_nxt = run_open_r;
    run_byte_nxt = run_byte_r;
    run_len_nxt  = run_len_r;
    pend_v_nxt   = pend_v_r;
    pend_job_nxt = pend_job_r;
    push         = 1'b0;
    push_data    = pend_job_r;
    if (pend_v_r) begin
      if (!q_full) begin
        push       = 1'b1;
        pend_v_nxt = 1'b0;
      end
    end else if (accept) begin
      if (same) begin
        if ((len_inc == BCD_MAX) || in_req.end_of_string) begin
          push         = 1'b1;
          push_data    = {in_req.end_of_string, run_byte_r, len_inc};
          run_open_nxt = 1'b0;
          run_len_nxt  = '0;
        end else begin
          run_len_nxt = len_inc;
        end
      end else begin
        if (run_open_r) begin
          // old run goes first, a closing new run waits in the pending register
          push      = 1'b1;
          push_data = {1'b0, run_byte_r, run_len_r};
          if (close_new) begin
            pend_v_nxt   = 1'b1;
            pend_job_nxt = new_job;
          end
        end else if (close_new) begin
          push      = 1'b1;
          push_data = new_job;
        end
        run_byte_nxt = in_req.symbol;
        run_open_nxt = !close_new;
        run_len_nxt  = close_new ? '0 : BCD_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_open_r <= 1'b0;
      run_byte_r <= '0;
      run_len_r  <= '0;
      pend_v_r   <= 1'b0;
    end else begin
      run_open_r <= run_open_nxt;
      run_byte_r <= run_byte_nxt;
      run_len_r  <= run_len_nxt;
      pend_v_r   <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_job_r <= pend_job_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/rldc_queue.sv -----
`default_nettype none

module rldc_queue import rldc_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  q_valid,
  output logic [WIDTH-1:0]      q_data
);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rldc_back.sv -----
`default_nettype none

module rldc_back import rldc_pkg::*; #(
  parameter int DIGITS = COUNT_DIGITS_DEF,
  localparam int BCD_W = 4 * DIGITS,
  localparam int JOB_W = 1 + 8 + BCD_W,
  localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire logic [JOB_W-1:0] q_data,
  output logic                  pop,
  rldc_out_if.source            out_rsp
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DIGIT = 2'b10
  } back_state_t;

  back_state_t      state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             last_r, last_nxt;

  logic             slot_free;
  logic             job_last;
  logic [7:0]       job_byte;
  logic [BCD_W-1:0] job_bcd;
  logic [IDX_W-1:0] job_top;
  logic [3:0]       digit;

  assign {job_last, job_byte, job_bcd} = q_data;
  assign slot_free = !out_valid_r || out_rsp.ready;
  assign digit     = bcd_r[idx_r*4 +: 4];

  // highest non-zero digit, units digit when all are zero
  always_comb begin
    job_top = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (job_bcd[i*4 +: 4] != 4'h0) begin
        job_top = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    bcd_nxt       = bcd_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    pop           = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (slot_free) begin
          out_valid_nxt = q_valid;
          if (q_valid) begin
            pop          = 1'b1;
            out_byte_nxt = job_byte;
            out_last_nxt = 1'b0;
            bcd_nxt      = job_bcd;
            idx_nxt      = job_top;
            last_nxt     = job_last;
            state_nxt    = S_DIGIT;
          end
        end
      end
      S_DIGIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = ASCII_ZERO + {4'h0, digit};
          out_last_nxt  = last_r && (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    bcd_r      <= bcd_nxt;
    idx_r      <= idx_nxt;
    last_r     <= last_nxt;
  end

  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.out_byte = out_byte_r;
  assign out_rsp.out_last = out_last_r;

endmodule

`default_nettype wire

// ----- hdl/run_length_decimal_compressor_top.sv -----
// run length compressor with decimal run counts
// in_req carries one string byte per request (symbol, end_of_string); out_rsp
// carries one output byte per request (out_byte, out_last). a run of equal
// bytes comes out as the byte followed by its length in ascii decimal, most
// significant digit first, no leading zeros. a run closes on a different
// byte, on end_of_string, or when the bcd counter reaches all nines
// the front takes one input request per cycle while in_req.ready is high and
// keeps the open run; each closed run becomes one request in a four-entry
// queue. a byte that both closes the old run and is flushed itself pushes
// two run requests, so in_req.ready stays low until the second is pushed
// the back sequencer emits one output byte per cycle while out_rsp.ready
// is high and the queue holds requests: the run byte, then its n digits.
// a closing request passes through the queue and then the output register
// in_req.ready falls while the queue is full; out_rsp holds its byte while
// out_rsp.ready is low, and the queue absorbs the front meanwhile
// synchronous reset clears the open run, the queue and the output register
`default_nettype none

module run_length_decimal_compressor_top import rldc_pkg::*; #(
  parameter int COUNT_DIGITS = COUNT_DIGITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rldc_in_if.sink    in_req,
  rldc_out_if.source out_rsp
);

  // the counter is limited to nine digits
  localparam int DIGITS = (COUNT_DIGITS > MAX_DIGITS) ? MAX_DIGITS :
                          ((COUNT_DIGITS < 1) ? 1 : COUNT_DIGITS);
  localparam int JOB_W  = 1 + 8 + 4 * DIGITS;

  // run request: last flag, run byte, bcd length
  logic             push;
  logic [JOB_W-1:0] push_data;
  logic             q_full;
  logic             pop;
  logic             q_valid;
  logic [JOB_W-1:0] q_data;

  rldc_front #(.DIGITS(DIGITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  rldc_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  rldc_back #(.DIGITS(DIGITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .out_rsp (out_rsp)
  );

endmodule

`default_nettype wire

// ----- hdl/rldc_checker.sv -----
`default_nettype none

module rldc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);

  // the closing byte of a string is always a length digit
  a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> (out_byte >= 8'h30) && (out_byte <= 8'h39))
    else $error("out_last on a non-digit byte");

  // stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output changed while stalled");

  // no output straight after reset
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // empty queue after reset accepts at once
  a_reset_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind run_length_decimal_compressor_top rldc_checker u_rldc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_req.ready),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .out_byte  (out_rsp.out_byte),
  .out_last  (out_rsp.out_last)
);

`default_nettype wire
